// ===== sv/brf_pkg.sv =====
`timescale 1ns / 1ps
// Shared sizes, codes and helpers for the block ring FIFO.
// No dependencies; imported by brf_ctrl, brf_dpath and block_ring_fifo_core.
package brf_pkg;

    localparam int BLOCKS      = 8;
    localparam int BLOCK_BYTES = 64;

    localparam int SLOT_W = $clog2(BLOCKS);
    localparam int FILL_W = $clog2(BLOCKS + 1);
    localparam int IDX_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int ADDR_W = $clog2(BLOCKS * BLOCK_BYTES);
    localparam int DEPTH  = BLOCKS * BLOCK_BYTES;

    // Fixed field widths
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] BLOCK_CAP   = CNT_W'(BLOCK_BYTES);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    // Controller -> datapath
    typedef struct packed {
        logic wr_byte;   // take one write byte
        logic rd_start;  // take a read request
        logic rd_push;   // move the fetched byte to the output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_valid;
        logic ring_empty;
        logic rd_zero;   // read request would copy nothing
        logic rd_last;   // byte being pushed ends the run
    } t_status;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0]  idx);
        int a;
        a = int'(slot) * BLOCK_BYTES + int'(idx);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/brf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the block ring FIFO: input handshake and read sequencing.
// Depends on brf_pkg; drives brf_dpath through t_cmd.
module brf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic             i_out_ready,
    input  brf_pkg::t_status i_status,
    output brf_pkg::t_cmd    o_cmd
);
    import brf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RD_PUSH
    } t_state;

    t_state r_state, n_state;
    logic   w_out_free;
    logic   w_take;

    // output register can take a new result this cycle
    assign w_out_free = !i_status.out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_operation == OP_WRITE) begin
                        o_cmd.wr_byte = 1'b1;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        if (!i_status.ring_empty && !i_status.rd_zero) begin
                            n_state = ST_RD_PUSH;
                        end
                    end
                end
            end
            ST_RD_PUSH: begin
                if (w_out_free) begin
                    o_cmd.rd_push = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/brf_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the block ring FIFO: frame store, slot ring, output register.
// Depends on brf_pkg; commanded by brf_ctrl.
module brf_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [brf_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic [brf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_frame_end,
    input  logic [brf_pkg::CNT_W-1:0]    i_read_limit,
    input  brf_pkg::t_cmd                i_cmd,
    output brf_pkg::t_status             o_status,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [1:0]                   o_result_kind,
    output logic [brf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_last,
    output logic [brf_pkg::CNT_W-1:0]    o_byte_count,
    output logic                         o_accepted
);
    import brf_pkg::*;

    // frame store
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_mem_q;
    logic              w_mem_we, w_mem_re;
    logic [ADDR_W-1:0] w_mem_waddr, w_mem_raddr;

    logic [CNT_W-1:0]  r_slot_len [BLOCKS];

    logic [CNT_W-1:0]  r_block_limit;
    logic [SLOT_W-1:0] r_read_slot, r_write_slot;
    logic [FILL_W-1:0] r_filled;
    logic [CNT_W-1:0]  r_write_fill;
    logic              r_frame_open, r_frame_refused;

    logic [SLOT_W-1:0] r_rd_slot;
    logic [CNT_W-1:0]  r_rd_idx, r_rd_n;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_acc;

    logic [CNT_W-1:0]  w_limit;
    logic              w_refused_now;
    logic [CNT_W-1:0]  w_fill_now, w_fill_new;
    logic              w_store;
    logic [CNT_W-1:0]  w_len, w_n;
    logic [CNT_W-1:0]  w_idx_next;
    logic [SLOT_W-1:0] w_write_slot_inc, w_read_slot_inc;

    assign w_limit       = (r_block_limit > BLOCK_CAP) ? BLOCK_CAP : r_block_limit;
    assign w_refused_now = r_frame_open ? r_frame_refused
                                        : (r_filled >= FILL_W'(BLOCKS));
    assign w_fill_now    = r_frame_open ? r_write_fill : '0;
    assign w_store       = !w_refused_now && (w_fill_now < w_limit);
    assign w_fill_new    = w_store ? w_fill_now + 1'b1 : w_fill_now;

    assign w_len = (r_slot_len[r_read_slot] > BLOCK_CAP) ? BLOCK_CAP
                                                         : r_slot_len[r_read_slot];
    assign w_n   = (w_len < i_read_limit) ? w_len : i_read_limit;

    assign w_idx_next = r_rd_idx + 1'b1;

    assign w_write_slot_inc = (r_write_slot == SLOT_W'(BLOCKS - 1)) ? '0
                                                                    : r_write_slot + 1'b1;
    assign w_read_slot_inc  = (r_read_slot == SLOT_W'(BLOCKS - 1)) ? '0
                                                                   : r_read_slot + 1'b1;

    assign w_mem_we    = i_cmd.wr_byte && w_store;
    assign w_mem_waddr = mem_addr(r_write_slot, w_fill_now[IDX_W-1:0]);

    // first byte fetched at read start, next byte fetched with each push
    assign w_mem_re    = (i_cmd.rd_start && r_filled != '0 && w_n != '0)
                      || (i_cmd.rd_push && (w_idx_next != r_rd_n));
    assign w_mem_raddr = i_cmd.rd_start ? mem_addr(r_read_slot, '0)
                                        : mem_addr(r_rd_slot, w_idx_next[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= i_data_byte;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_raddr];
        end
    end

    // ring and write-frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit   <= LIMIT_RESET;
            r_read_slot     <= '0;
            r_write_slot    <= '0;
            r_filled        <= '0;
            r_write_fill    <= '0;
            r_frame_open    <= 1'b0;
            r_frame_refused <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_block_limit <= i_cfg_wr_data;
            end
            if (i_cmd.wr_byte) begin
                if (i_frame_end) begin
                    if (!w_refused_now) begin
                        r_write_slot <= w_write_slot_inc;
                        r_filled     <= r_filled + 1'b1;
                    end
                    r_frame_open    <= 1'b0;
                    r_frame_refused <= 1'b0;
                    r_write_fill    <= '0;
                end else begin
                    r_frame_open    <= 1'b1;
                    r_frame_refused <= w_refused_now;
                    r_write_fill    <= w_fill_new;
                end
            end
            if (i_cmd.rd_start && r_filled != '0) begin
                r_read_slot <= w_read_slot_inc;
                r_filled    <= r_filled - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte && i_frame_end && !w_refused_now) begin
            r_slot_len[r_write_slot] <= w_fill_new;
        end
        if (i_cmd.rd_start) begin
            r_rd_slot <= r_read_slot;
            r_rd_idx  <= '0;
            r_rd_n    <= w_n;
        end else if (i_cmd.rd_push) begin
            r_rd_idx <= w_idx_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.wr_byte && i_frame_end) || i_cmd.rd_push
                     || (i_cmd.rd_start && (r_filled == '0 || w_n == '0))) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte && i_frame_end) begin
            r_out_kind  <= KIND_ACK;
            r_out_byte  <= '0;
            r_out_last  <= 1'b1;
            r_out_count <= w_refused_now ? '0 : w_fill_new;
            r_out_acc   <= !w_refused_now;
        end else if (i_cmd.rd_start) begin
            r_out_kind  <= (r_filled == '0) ? KIND_EMPTY : KIND_DATA;
            r_out_byte  <= '0;
            r_out_last  <= 1'b1;
            r_out_count <= '0;
            r_out_acc   <= 1'b0;
        end else if (i_cmd.rd_push) begin
            r_out_kind  <= KIND_DATA;
            r_out_byte  <= r_mem_q;
            r_out_last  <= (w_idx_next == r_rd_n);
            r_out_count <= r_rd_n;
            r_out_acc   <= 1'b0;
        end
    end

    assign o_status.out_valid  = r_out_valid;
    assign o_status.ring_empty = (r_filled == '0);
    assign o_status.rd_zero    = (w_n == '0);
    assign o_status.rd_last    = (w_idx_next == r_rd_n);

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_last        = r_out_last;
    assign o_byte_count  = r_out_count;
    assign o_accepted    = r_out_acc;

endmodule

// ===== sv/block_ring_fifo_core.sv =====
`timescale 1ns / 1ps
// Block ring FIFO: a ring of BLOCKS frame slots of BLOCK_BYTES bytes each.
// Top level; depends on brf_pkg, brf_ctrl and brf_dpath.
//
// Input channel (i_in_valid / o_in_ready) carries write bytes and read
// requests. Write bytes are taken one per cycle while ready; the byte with
// frame_end set commits the frame and returns one acknowledgement with the
// stored count, or accepted = 0 if the ring was full when the frame began.
// A read request dequeues the oldest frame and returns min(length, limit)
// data bytes, last set on the final one; a zero-length copy returns one
// result with count 0, and an empty ring returns one empty result.
// Output channel (o_out_valid / i_out_ready) is a single output register.
// An ack, empty result or zero-length copy enters the output register as its
// request is taken. Read data passes the registered store read, then the output
// register, one byte per cycle while the receiver takes it; no new request is
// taken until the last byte is pushed. A new request is taken only while the
// output register is empty or being drained; a stalled receiver holds both
// sides. block_limit is written via i_cfg_wr_en / i_cfg_wr_data, by the user
// only while idle; the block does not enforce this. Reset (synchronous, active
// low) empties the ring and sets block_limit to 64; it needs no clearing pass.
module block_ring_fifo_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [brf_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [brf_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_frame_end,
    input  logic [brf_pkg::CNT_W-1:0]   i_read_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_result_kind,
    output logic [brf_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last,
    output logic [brf_pkg::CNT_W-1:0]   o_byte_count,
    output logic                        o_accepted
);
    import brf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    brf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_data_byte   (i_data_byte),
        .i_frame_end   (i_frame_end),
        .i_read_limit  (i_read_limit),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_byte_count  (o_byte_count),
        .o_accepted    (o_accepted)
    );

endmodule

// ===== test/tb_block_ring_fifo_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_ring_fifo_core: directed and random frame traffic,
// checked against an in-bench ring predictor. Depends on brf_pkg and the core RTL.
module tb_block_ring_fifo_core;
    import brf_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  count;
        logic              acc;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CNT_W-1:0]   i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic [BYTE_W-1:0]  i_data_byte;
    logic               i_frame_end;
    logic [CNT_W-1:0]   i_read_limit;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_result_kind;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_last;
    logic [CNT_W-1:0]   o_byte_count;
    logic               o_accepted;

    block_ring_fifo_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .i_frame_end   (i_frame_end),
        .i_read_limit  (i_read_limit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_byte_count  (o_byte_count),
        .o_accepted    (o_accepted)
    );

    // Predictor state
    logic [BYTE_W-1:0] frame_mem [DEPTH];
    logic [CNT_W-1:0]  slot_len [BLOCKS];
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    int                used_slots;
    int                fill_cnt;
    logic              frame_active;
    logic              frame_dropped;
    logic [CNT_W-1:0]  limit_reg;

    t_result pending_results[$];
    int      fail_count;
    int      items_sent;
    int      burst_left;
    logic    gaps_on;
    int      stall_mode;
    logic    hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic void push_result(t_kind kind, logic [BYTE_W-1:0] data, logic last,
                                        int count, logic acc);
        t_result r;
        r.kind  = kind;
        r.data  = data;
        r.last  = last;
        r.count = CNT_W'(count);
        r.acc   = acc;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_ring_results(logic op, logic [BYTE_W-1:0] data,
                                                 logic fend, logic [CNT_W-1:0] rlim);
        int eff_limit;
        int len;
        int n;
        if (op == OP_WRITE) begin
            eff_limit = (int'(limit_reg) < BLOCK_BYTES) ? int'(limit_reg) : BLOCK_BYTES;
            // fullness is decided once, at the frame's first byte
            if (!frame_active) begin
                frame_active  = 1'b1;
                fill_cnt      = 0;
                frame_dropped = (used_slots >= BLOCKS);
            end
            if (!frame_dropped && fill_cnt < eff_limit) begin
                frame_mem[int'(wr_slot) * BLOCK_BYTES + fill_cnt] = data;
                fill_cnt++;
            end
            if (fend) begin
                if (frame_dropped) begin
                    push_result(KIND_ACK, '0, 1'b1, 0, 1'b0);
                end else begin
                    slot_len[wr_slot] = CNT_W'(fill_cnt);
                    wr_slot = wr_slot + 1'b1;
                    used_slots++;
                    push_result(KIND_ACK, '0, 1'b1, fill_cnt, 1'b1);
                end
                frame_active  = 1'b0;
                frame_dropped = 1'b0;
                fill_cnt      = 0;
            end
        end else if (used_slots == 0) begin
            push_result(KIND_EMPTY, '0, 1'b1, 0, 1'b0);
        end else begin
            len = int'(slot_len[rd_slot]);
            if (len > BLOCK_BYTES) len = BLOCK_BYTES;
            n = (len < int'(rlim)) ? len : int'(rlim);
            if (n == 0) begin
                push_result(KIND_DATA, '0, 1'b1, 0, 1'b0);
            end else begin
                for (int i = 0; i < n; i++) begin
                    push_result(KIND_DATA, frame_mem[int'(rd_slot) * BLOCK_BYTES + i],
                                (i + 1 == n), n, 1'b0);
                end
            end
            rd_slot = rd_slot + 1'b1;
            used_slots--;
        end
    endfunction

    // Receiver: long hold on request, else per-phase stall behavior
    int         hold_cycles;
    int         rx_cycle;
    logic [7:0] ready_pattern;
    always @(posedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 64 == 0) ready_pattern = 8'($urandom) | 8'h01;
        else ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles  = 300;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(99) < 70);
                default: i_out_ready <= ready_pattern[0];
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d byte %0h count %0d",
                       o_result_kind, o_out_byte, o_byte_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                    fail_count++;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
                if (o_byte_count !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, o_byte_count);
                    fail_count++;
                end
                if (o_accepted !== want.acc) begin
                    $error("accepted: expected %0d, got %0d", want.acc, o_accepted);
                    fail_count++;
                end
            end
        end
    end

    // One request; valid stays high afterward unless the next call opens a gap
    task automatic send_request(logic op, logic [BYTE_W-1:0] data, logic fend,
                                logic [CNT_W-1:0] rlim);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        i_frame_end <= fend;
        i_read_limit <= rlim;
        do @(posedge i_clk); while (!o_in_ready);
        predict_ring_results(op, data, fend, rlim);
        items_sent++;
    endtask

    function automatic logic [CNT_W-1:0] pick_read_limit();
        case ($urandom_range(9))
            0: return '0;
            1: return {CNT_W{1'b1}};
            2, 3, 4, 5: return CNT_W'($urandom_range(1, 8));
            default: return CNT_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_read(logic [CNT_W-1:0] rlim);
        send_request(OP_READ, 8'($urandom), 1'($urandom), rlim);
    endtask

    task automatic send_frame(int len, int read_pct);
        for (int i = 0; i < len; i++) begin
            send_request(OP_WRITE, 8'($urandom), (i == len - 1), CNT_W'($urandom));
            if (i < len - 1 && $urandom_range(99) < read_pct) send_read(pick_read_limit());
        end
    endtask

    // Drain all results, then allow for a write byte still in flight
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_block_limit(logic [CNT_W-1:0] value);
        settle_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        limit_reg = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_empty_reads();
        send_read('0);
        send_read({CNT_W{1'b1}});
    endtask

    task automatic test_basic_frames();
        send_request(OP_WRITE, 8'h00, 1'b1, '0);
        send_request(OP_WRITE, 8'hFF, 1'b0, {CNT_W{1'b1}});
        send_request(OP_WRITE, 8'h5A, 1'b1, '0);
        send_request(OP_WRITE, 8'hA5, 1'b1, '0);
        send_read({CNT_W{1'b1}});
        send_read(CNT_W'(1));          // two stored bytes, one copied
        send_read('0);                 // zero-length copy still dequeues
        send_read(CNT_W'(64));
    endtask

    task automatic test_ring_full();
        for (int i = 0; i < BLOCKS; i++) send_request(OP_WRITE, 8'(i * 37), 1'b1, '0);
        // frame opens on a full ring; the read frees a slot but the frame stays refused
        send_request(OP_WRITE, 8'h3C, 1'b0, '0);
        send_read(CNT_W'(2));
        send_request(OP_WRITE, 8'hC3, 1'b1, '0);
        send_request(OP_WRITE, 8'h81, 1'b1, '0);
        send_read(CNT_W'(8));
    endtask

    task automatic test_random_traffic(logic [CNT_W-1:0] limit, int n_items, int write_pct,
                                       int stall, logic gaps, logic long_hold);
        int target;
        int len;
        set_block_limit(limit);
        stall_mode = stall;
        gaps_on    = gaps;
        burst_left = 0;
        if (long_hold) hold_request = 1'b1;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(99) < write_pct) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(7, 70) : $urandom_range(1, 6);
                send_frame(len, 10);
            end else begin
                send_read(pick_read_limit());
            end
        end
    endtask

    initial begin
        rd_slot       = '0;
        wr_slot       = '0;
        used_slots    = 0;
        fill_cnt      = 0;
        frame_active  = 1'b0;
        frame_dropped = 1'b0;
        limit_reg     = LIMIT_RESET;
        fail_count    = 0;
        items_sent    = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        stall_mode    = 0;
        hold_request  = 1'b0;
        hold_cycles   = 0;
        rx_cycle      = 0;
        ready_pattern = 8'hB5;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_WRITE;
        i_data_byte   <= '0;
        i_frame_end   <= 1'b0;
        i_read_limit  <= '0;
        i_out_ready   <= 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reads();
        test_basic_frames();
        test_ring_full();
        test_random_traffic(CNT_W'(64), 25, 60, 0, 1'b1, 1'b0);
        test_random_traffic('0, 15, 50, 1, 1'b0, 1'b0);
        test_random_traffic({CNT_W{1'b1}}, 25, 80, 2, 1'b1, 1'b1);
        test_random_traffic(CNT_W'(1), 15, 50, 1, 1'b1, 1'b0);
        test_random_traffic(CNT_W'($urandom_range(2, 63)), 35, 50, 2, 1'b1, 1'b0);

        settle_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
